/* rtl/brt_pkg.sv */
// Shared types and constants of the braking path resampler and truncator.
// Used by the controller, the datapath and the top level; no dependencies.
package brt_pkg;

  // Configuration register widths and reset values.
  localparam int unsigned DECEL_W  = 16;
  localparam int unsigned DELAY_W  = 14;
  localparam int unsigned SPACE_W  = 20;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned CFG_IDXW = 2;

  localparam logic [DECEL_W-1:0] DECEL_RST = 16'd256;
  localparam logic [DELAY_W-1:0] DELAY_RST = 14'd0;
  localparam logic [SPACE_W-1:0] SPACE_RST = 20'd1024;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDXW-1:0] REG_MAX_DECEL      = 2'd0;
  localparam logic [CFG_IDXW-1:0] REG_REACTION_DELAY = 2'd1;
  localparam logic [CFG_IDXW-1:0] REG_MIN_SPACING    = 2'd2;

  // Fixed field widths.
  localparam int unsigned HEAD_W = 16;
  localparam int unsigned SPD_W  = 16;
  localparam int unsigned LEN_W  = 32;

  localparam logic [LEN_W-1:0] LEN_MAX = 32'hFFFF_FFFF;

  // Braking length: 500*v^2 + delay*v*a over 250*a, speeds under 3 are zero.
  localparam logic [SPD_W-1:0] SPD_MIN    = 16'd3;
  localparam logic [8:0]       BRK_V2_MUL = 9'd500;
  localparam logic [7:0]       BRK_A_MUL  = 8'd250;

  // Quotient bits produced by the iterative divider.
  localparam int unsigned QB = 48;

  // Datapath commands.
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_BRK1,
    CMD_BRK2,
    CMD_DIV,
    CMD_FIRST,
    CMD_SETCUT,
    CMD_SQX,
    CMD_SQY,
    CMD_MS,
    CMD_REM,
    CMD_SQZ,
    CMD_SQRT2,
    CMD_SQRT3,
    CMD_IPM,
    CMD_IPW,
    CMD_ADV,
    CMD_EMIT_IN,
    CMD_EMIT_IP
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic iter_busy;
    logic out_full;
    logic first;
    logic last;
    logic cut;
    logic trav_ge_lim;
    logic thin;
    logic cut_here;
  } stat_t;

endpackage

/* rtl/braking_path_resample_and_truncate_top.sv */
// Top level of the braking path resampler and truncator.
// Depends on brt_pkg, brt_ctrl, brt_dpath (and brt_iter below it).
//
// Trajectory points enter on the slave stream, one transfer per point;
// tuser flags the first point and tlast the last point of a trajectory.
// Kept and truncated points leave on the master stream; tlast marks the
// final point of the truncated path. Three configuration registers
// (max_decel, reaction_delay, min_spacing) are written through the plain
// write port; the user must write them only while the block is idle,
// as the block itself does not enforce it. One point is worked on at a
// time. A first point waits for the 48-bit quotient of the braking-length
// division. A passed point waits for the bit-serial square root of the
// 2-D length. The cut point needs one 3-D root and three divisions on the
// shared iterative unit.
// The result sits in an output register; when the receiver stalls, the
// block finishes its work and waits only before it loads the next result.
// Reset sets the registers to their defaults and clears the path state.
module braking_path_resample_and_truncate_top #(
  parameter int unsigned POS_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [brt_pkg::CFG_IDXW-1:0]    cfg_idx_i,
  input  logic [brt_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // pos_x, pos_y, pos_z, heading, speed (from bit 0 up), zero filled
  input  logic [((3*POS_BITS+32+7)/8)*8-1:0] s_axis_tdata_i,
  // first_point
  input  logic                            s_axis_tuser_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out_x, out_y, out_z, out_heading (from bit 0 up), zero filled
  output logic [((3*POS_BITS+16+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);

  localparam int unsigned P    = POS_BITS;
  localparam int unsigned OUTW = ((3 * P + 16 + 7) / 8) * 8;
  localparam int unsigned OPAD = OUTW - (3 * P + 16);

  brt_pkg::cmd_t  cmd;
  brt_pkg::stat_t stat;

  logic signed [P-1:0]        ox, oy, oz;
  logic [brt_pkg::HEAD_W-1:0] ohd;

  brt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  brt_dpath #(
    .P(P)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pos_x_i      (s_axis_tdata_i[P-1:0]),
    .pos_y_i      (s_axis_tdata_i[2*P-1:P]),
    .pos_z_i      (s_axis_tdata_i[3*P-1:2*P]),
    .heading_i    (s_axis_tdata_i[3*P+15:3*P]),
    .speed_i      (s_axis_tdata_i[3*P+31:3*P+16]),
    .first_i      (s_axis_tuser_i),
    .last_i       (s_axis_tlast_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_x_o      (ox),
    .out_y_o      (oy),
    .out_z_o      (oz),
    .out_heading_o(ohd),
    .path_end_o   (m_axis_tlast_o)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata_o = OUTW'({{(OPAD + 1){1'b0}}, ohd, oz, oy, ox});

endmodule

/* rtl/brt_iter.sv */
// Iterative unit: bit-serial integer square root and restoring division.
// One result bit per cycle; no package dependencies.
module brt_iter #(
  parameter int unsigned SW  = 68,
  parameter int unsigned NW  = 65,
  parameter int unsigned DVW = 34,
  parameter int unsigned QBITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_sqrt_i,
  input  logic                 start_div_i,
  input  logic [SW-1:0]        rad_i,
  input  logic [NW-1:0]        num_i,
  input  logic [DVW-1:0]       den_i,
  output logic                 busy_o,
  output logic [((QBITS > SW/2) ? QBITS : SW/2)-1:0] res_o
);

  localparam int unsigned RW   = SW / 2;
  localparam int unsigned RESW = (QBITS > RW) ? QBITS : RW;
  localparam int unsigned RMW  = ((DVW + 1) > (RW + 3)) ? (DVW + 1) : (RW + 3);
  localparam int unsigned ITW  = $clog2(RESW + 1);

  logic            busy_q, mode_q;
  logic [ITW-1:0]  cnt_q;
  logic [RMW-1:0]  rem_q, rem_d, sh_sq, sh_dv, trial;
  logic [SW-1:0]   rad_q;
  logic [NW-1:0]   num_q;
  logic [DVW-1:0]  den_q;
  logic [RESW-1:0] res_q, res_d;

  // One step of the selected recurrence.
  always_comb begin
    sh_sq = RMW'({rem_q, rad_q[SW-1:SW-2]});
    sh_dv = RMW'({rem_q, num_q[NW-1]});
    trial = RMW'({res_q, 2'b01});
    rem_d = rem_q;
    res_d = res_q;
    if (mode_q) begin
      if (sh_dv >= RMW'(den_q)) begin
        rem_d = sh_dv - RMW'(den_q);
        res_d = {res_q[RESW-2:0], 1'b1};
      end else begin
        rem_d = sh_dv;
        res_d = {res_q[RESW-2:0], 1'b0};
      end
    end else begin
      if (sh_sq >= trial) begin
        rem_d = sh_sq - trial;
        res_d = {res_q[RESW-2:0], 1'b1};
      end else begin
        rem_d = sh_sq;
        res_d = {res_q[RESW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_sqrt_i || start_div_i) begin
      busy_q <= 1'b1;
      cnt_q  <= start_div_i ? ITW'(QBITS) : ITW'(RW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == ITW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    if (start_sqrt_i) begin
      mode_q <= 1'b0;
      rad_q  <= rad_i;
      rem_q  <= '0;
      res_q  <= '0;
    end else if (start_div_i) begin
      mode_q <= 1'b1;
      num_q  <= num_i << (NW - QBITS);
      den_q  <= den_i;
      rem_q  <= RMW'(num_i >> QBITS);
      res_q  <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      num_q <= num_q << 1;
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign busy_o = busy_q;
  assign res_o  = res_q;

endmodule

/* rtl/brt_dpath.sv */
// Datapath: input and path state registers, per-command multiplies, output register.
// Depends on brt_pkg and brt_iter.
module brt_dpath #(
  parameter int unsigned P = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  brt_pkg::cmd_t                   cmd_i,
  output brt_pkg::stat_t                  stat_o,
  input  logic                            cfg_we_i,
  input  logic [brt_pkg::CFG_IDXW-1:0]    cfg_idx_i,
  input  logic [brt_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic signed [P-1:0]             pos_x_i,
  input  logic signed [P-1:0]             pos_y_i,
  input  logic signed [P-1:0]             pos_z_i,
  input  logic [brt_pkg::HEAD_W-1:0]      heading_i,
  input  logic [brt_pkg::SPD_W-1:0]       speed_i,
  input  logic                            first_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [P-1:0]             out_x_o,
  output logic signed [P-1:0]             out_y_o,
  output logic signed [P-1:0]             out_z_o,
  output logic [brt_pkg::HEAD_W-1:0]      out_heading_o,
  output logic                            path_end_o
);

  localparam int unsigned DW   = P + 1;
  localparam int unsigned SW   = 2 * P + 4;
  localparam int unsigned RW   = SW / 2;
  localparam int unsigned NW   = ((P + 33) > 47) ? (P + 33) : 47;
  localparam int unsigned DVW  = ((P + 2) > 24) ? (P + 2) : 24;
  localparam int unsigned RESW = (brt_pkg::QB > RW) ? brt_pkg::QB : RW;
  localparam int unsigned CW   = (SW > 64) ? SW : 64;
  localparam int unsigned TW   = ((RW > 32) ? RW : 32) + 1;

  // Configuration registers.
  logic [brt_pkg::DECEL_W-1:0] decel_q;
  logic [brt_pkg::DELAY_W-1:0] delay_q;
  logic [brt_pkg::SPACE_W-1:0] space_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decel_q <= brt_pkg::DECEL_RST;
      delay_q <= brt_pkg::DELAY_RST;
      space_q <= brt_pkg::SPACE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == brt_pkg::REG_MAX_DECEL) begin
        decel_q <= cfg_data_i[brt_pkg::DECEL_W-1:0];
      end
      if (cfg_idx_i == brt_pkg::REG_REACTION_DELAY) begin
        delay_q <= cfg_data_i[brt_pkg::DELAY_W-1:0];
      end
      if (cfg_idx_i == brt_pkg::REG_MIN_SPACING) begin
        space_q <= cfg_data_i[brt_pkg::SPACE_W-1:0];
      end
    end
  end

  // Captured input item.
  logic signed [P-1:0]          x_q, y_q, z_q;
  logic [brt_pkg::HEAD_W-1:0]   hd_q;
  logic [brt_pkg::SPD_W-1:0]    spd_q;
  logic                         first_q, last_q;

  // Path state.
  logic signed [P-1:0]          kx_q, ky_q, kz_q;
  logic [brt_pkg::LEN_W-1:0]    trav_q, lim_q;
  logic                         cut_q;

  // Working registers.
  logic [31:0]                  t1_q;
  logic [29:0]                  t2_q;
  logic [SW-1:0]                s2_q, s3_q;
  logic [39:0]                  ms2_q;
  logic [63:0]                  r2_q;
  logic [NW-1:0]                num_q;
  logic [DVW-1:0]               den_q;
  logic [RW-1:0]                len_q;
  logic signed [P-1:0]          ip_q [3];

  // Output register.
  logic                         ov_q;
  logic signed [P-1:0]          ox_q, oy_q, oz_q;
  logic [brt_pkg::HEAD_W-1:0]   ohd_q;
  logic                         oend_q;

  // Iterative unit.
  logic            it_busy;
  logic [RESW-1:0] it_res;

  brt_iter #(
    .SW   (SW),
    .NW   (NW),
    .DVW  (DVW),
    .QBITS(brt_pkg::QB)
  ) u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_sqrt_i(cmd_i.op == brt_pkg::CMD_SQRT2 || cmd_i.op == brt_pkg::CMD_SQRT3),
    .start_div_i (cmd_i.op == brt_pkg::CMD_DIV),
    .rad_i       ((cmd_i.op == brt_pkg::CMD_SQRT3) ? s3_q : s2_q),
    .num_i       (num_q),
    .den_i       (den_q),
    .busy_o      (it_busy),
    .res_o       (it_res)
  );

  // Differences from the last kept point and their magnitudes.
  logic signed [DW-1:0] dx, dy, dz, dsel;
  logic [DW-1:0]        mx, my, mz, msel;
  logic signed [P-1:0]  ksel;
  logic [brt_pkg::LEN_W-1:0] remain;

  always_comb begin
    dx = $signed({x_q[P-1], x_q}) - $signed({kx_q[P-1], kx_q});
    dy = $signed({y_q[P-1], y_q}) - $signed({ky_q[P-1], ky_q});
    dz = $signed({z_q[P-1], z_q}) - $signed({kz_q[P-1], kz_q});
    mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    my = dy[DW-1] ? DW'(-dy) : DW'(dy);
    mz = dz[DW-1] ? DW'(-dz) : DW'(dz);
    remain = lim_q - trav_q;
    unique case (cmd_i.axis)
      2'd0: begin
        dsel = dx; msel = mx; ksel = kx_q;
      end
      2'd1: begin
        dsel = dy; msel = my; ksel = ky_q;
      end
      default: begin
        dsel = dz; msel = mz; ksel = kz_q;
      end
    endcase
  end

  // Braking length from the divider quotient.
  logic [brt_pkg::LEN_W-1:0] brk_len;

  always_comb begin
    priority if (spd_q < brt_pkg::SPD_MIN) begin
      brk_len = '0;
    end else if (decel_q == '0) begin
      brk_len = brt_pkg::LEN_MAX;
    end else if (it_res[brt_pkg::QB-1:brt_pkg::LEN_W] != '0) begin
      brk_len = brt_pkg::LEN_MAX;
    end else begin
      brk_len = it_res[brt_pkg::LEN_W-1:0];
    end
  end

  // Travelled length after the new segment, saturating.
  logic [TW-1:0]             tsum;
  logic [brt_pkg::LEN_W-1:0] trav_new;

  always_comb begin
    tsum     = TW'(trav_q) + TW'(it_res[RW-1:0]);
    trav_new = (tsum > TW'(brt_pkg::LEN_MAX)) ? brt_pkg::LEN_MAX : tsum[brt_pkg::LEN_W-1:0];
  end

  // Interpolation offset, reduced to the coordinate width.
  logic [P+31:0]       offw;
  logic signed [P-1:0] offp;

  always_comb begin
    offw = {{P{1'b0}}, it_res[31:0]};
    offp = offw[P-1:0];
  end

  // Input capture and command execution.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      brt_pkg::CMD_LOAD: begin
        x_q     <= pos_x_i;
        y_q     <= pos_y_i;
        z_q     <= pos_z_i;
        hd_q    <= heading_i;
        spd_q   <= speed_i;
        first_q <= first_i;
        last_q  <= last_i;
      end
      brt_pkg::CMD_BRK1: begin
        t1_q <= 32'(spd_q) * 32'(spd_q);
        t2_q <= 30'(delay_q) * 30'(spd_q);
      end
      brt_pkg::CMD_BRK2: begin
        num_q <= NW'(47'(t1_q) * 47'(brt_pkg::BRK_V2_MUL)) + NW'(47'(t2_q) * 47'(decel_q));
        den_q <= DVW'(24'(decel_q) * 24'(brt_pkg::BRK_A_MUL));
      end
      brt_pkg::CMD_SQX: begin
        s2_q <= SW'(mx) * SW'(mx);
      end
      brt_pkg::CMD_SQY: begin
        s2_q <= s2_q + SW'(my) * SW'(my);
      end
      brt_pkg::CMD_MS: begin
        ms2_q <= 40'(space_q) * 40'(space_q);
      end
      brt_pkg::CMD_REM: begin
        r2_q <= 64'(remain) * 64'(remain);
      end
      brt_pkg::CMD_SQZ: begin
        s3_q <= s2_q + SW'(mz) * SW'(mz);
      end
      brt_pkg::CMD_IPM: begin
        num_q <= NW'(remain) * NW'(msel);
        // On the first axis the 3-D length comes straight from the root.
        den_q <= DVW'((cmd_i.axis == 2'd0) ? it_res[RW-1:0] : len_q);
      end
      brt_pkg::CMD_IPW: begin
        ip_q[cmd_i.axis] <= dsel[DW-1] ? (ksel - offp) : (ksel + offp);
      end
      brt_pkg::CMD_SQRT2, brt_pkg::CMD_SQRT3, brt_pkg::CMD_DIV,
      brt_pkg::CMD_FIRST, brt_pkg::CMD_SETCUT, brt_pkg::CMD_ADV,
      brt_pkg::CMD_EMIT_IN, brt_pkg::CMD_EMIT_IP, brt_pkg::CMD_NONE: begin
      end
      default: begin
      end
    endcase
    // The 3-D length is held once the root is ready, for the second and third axes.
    if (cmd_i.op == brt_pkg::CMD_IPM && cmd_i.axis == 2'd0) begin
      len_q <= it_res[RW-1:0];
    end
  end

  // Path state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kx_q   <= '0;
      ky_q   <= '0;
      kz_q   <= '0;
      trav_q <= '0;
      lim_q  <= '0;
      cut_q  <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        brt_pkg::CMD_FIRST: begin
          lim_q  <= brk_len;
          trav_q <= '0;
          kx_q   <= x_q;
          ky_q   <= y_q;
          kz_q   <= z_q;
          cut_q  <= (brk_len == '0);
        end
        brt_pkg::CMD_SETCUT, brt_pkg::CMD_EMIT_IP: begin
          cut_q <= 1'b1;
        end
        brt_pkg::CMD_ADV: begin
          trav_q <= trav_new;
          kx_q   <= x_q;
          ky_q   <= y_q;
          kz_q   <= z_q;
          cut_q  <= last_q || (trav_new >= lim_q);
        end
        default: begin
        end
      endcase
    end
  end

  // Output register; one transfer waits here while the next is worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.op == brt_pkg::CMD_EMIT_IN || cmd_i.op == brt_pkg::CMD_EMIT_IP) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == brt_pkg::CMD_EMIT_IN) begin
      ox_q   <= x_q;
      oy_q   <= y_q;
      oz_q   <= z_q;
      ohd_q  <= hd_q;
      oend_q <= cut_q;
    end else if (cmd_i.op == brt_pkg::CMD_EMIT_IP) begin
      ox_q   <= ip_q[0];
      oy_q   <= ip_q[1];
      oz_q   <= ip_q[2];
      ohd_q  <= hd_q;
      oend_q <= 1'b1;
    end
  end

  // Status to the controller.
  always_comb begin
    stat_o.iter_busy   = it_busy;
    stat_o.out_full    = ov_q;
    stat_o.first       = first_q;
    stat_o.last        = last_q;
    stat_o.cut         = cut_q;
    stat_o.trav_ge_lim = (trav_q >= lim_q);
    stat_o.thin        = !last_q && (CW'(s2_q) <= CW'(ms2_q));
    stat_o.cut_here    = (CW'(r2_q) <= CW'(s2_q));
  end

  assign out_valid_o   = ov_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign out_z_o       = oz_q;
  assign out_heading_o = ohd_q;
  assign path_end_o    = oend_q;

endmodule

/* rtl/brt_ctrl.sv */
// Controller: sequences the datapath commands for one point at a time.
// Depends on brt_pkg.
module brt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  brt_pkg::stat_t stat_i,
  output brt_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_BRK1, S_BRK2, S_DIVB, S_WDIVB, S_FIRST, S_EMF,
    S_CHK, S_SQY, S_MS, S_REM, S_DEC, S_S3, S_WS3, S_IPM, S_DIVI,
    S_WDI, S_IPW, S_EMI, S_WS2, S_ADV, S_EMA
  } state_e;

  state_e     state_q;
  logic [1:0] axis_q;

  assign in_ready_o = (state_q == S_IDLE);

  // Command decode from the current state.
  always_comb begin
    cmd_o.op   = brt_pkg::CMD_NONE;
    cmd_o.axis = axis_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) cmd_o.op = brt_pkg::CMD_LOAD;
      S_BRK1:  cmd_o.op = brt_pkg::CMD_BRK1;
      S_BRK2:  cmd_o.op = brt_pkg::CMD_BRK2;
      S_DIVB:  cmd_o.op = brt_pkg::CMD_DIV;
      S_FIRST: cmd_o.op = brt_pkg::CMD_FIRST;
      S_EMF, S_EMA: if (!stat_i.out_full) cmd_o.op = brt_pkg::CMD_EMIT_IN;
      S_CHK: begin
        priority if (stat_i.cut) cmd_o.op = brt_pkg::CMD_NONE;
        else if (stat_i.trav_ge_lim) cmd_o.op = brt_pkg::CMD_SETCUT;
        else cmd_o.op = brt_pkg::CMD_SQX;
      end
      S_SQY:   cmd_o.op = brt_pkg::CMD_SQY;
      S_MS:    cmd_o.op = brt_pkg::CMD_MS;
      S_REM:   cmd_o.op = brt_pkg::CMD_REM;
      S_DEC: begin
        priority if (stat_i.thin) cmd_o.op = brt_pkg::CMD_NONE;
        else if (stat_i.cut_here) cmd_o.op = brt_pkg::CMD_SQZ;
        else cmd_o.op = brt_pkg::CMD_SQRT2;
      end
      S_S3:    cmd_o.op = brt_pkg::CMD_SQRT3;
      S_IPM:   cmd_o.op = brt_pkg::CMD_IPM;
      S_DIVI:  cmd_o.op = brt_pkg::CMD_DIV;
      S_IPW:   cmd_o.op = brt_pkg::CMD_IPW;
      S_EMI:   if (!stat_i.out_full) cmd_o.op = brt_pkg::CMD_EMIT_IP;
      S_ADV:   cmd_o.op = brt_pkg::CMD_ADV;
      default: cmd_o.op = brt_pkg::CMD_NONE;
    endcase
  end

  // State sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 2'd0;
    end else begin
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_DISP;
        S_DISP:  state_q <= stat_i.first ? S_BRK1 : S_CHK;
        S_BRK1:  state_q <= S_BRK2;
        S_BRK2:  state_q <= S_DIVB;
        S_DIVB:  state_q <= S_WDIVB;
        S_WDIVB: if (!stat_i.iter_busy) state_q <= S_FIRST;
        S_FIRST: state_q <= S_EMF;
        S_EMF: begin
          if (!stat_i.out_full) state_q <= stat_i.last ? S_CHK : S_IDLE;
        end
        S_CHK: begin
          state_q <= (stat_i.cut || stat_i.trav_ge_lim) ? S_IDLE : S_SQY;
        end
        S_SQY:   state_q <= S_MS;
        S_MS:    state_q <= S_REM;
        S_REM:   state_q <= S_DEC;
        S_DEC: begin
          priority if (stat_i.thin) state_q <= S_IDLE;
          else if (stat_i.cut_here) state_q <= S_S3;
          else state_q <= S_WS2;
        end
        S_S3:    state_q <= S_WS3;
        S_WS3: begin
          if (!stat_i.iter_busy) begin
            axis_q  <= 2'd0;
            state_q <= S_IPM;
          end
        end
        S_IPM:   state_q <= S_DIVI;
        S_DIVI:  state_q <= S_WDI;
        S_WDI:   if (!stat_i.iter_busy) state_q <= S_IPW;
        S_IPW: begin
          if (axis_q == 2'd2) begin
            state_q <= S_EMI;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_IPM;
          end
        end
        S_EMI:   if (!stat_i.out_full) state_q <= S_IDLE;
        S_WS2:   if (!stat_i.iter_busy) state_q <= S_ADV;
        S_ADV:   state_q <= S_EMA;
        S_EMA:   if (!stat_i.out_full) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/braking_path_resample_and_truncate_top_tb.sv */
// Self-checking testbench for the braking path resampler and truncator.
// Depends on brt_pkg and braking_path_resample_and_truncate_top; it predicts
// every emitted point and compares it field by field with the master stream.
module braking_path_resample_and_truncate_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES = 400;

  typedef struct {
    logic [31:0] x, y, z;
    logic [15:0] hd, spd;
    logic        first, last;
  } point_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic [15:0] hd;
    logic        fin;
  } emit_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_idx = '0;
  logic [19:0]  cfg_data = '0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [127:0] s_data = '0;
  logic         s_user = 1'b0;
  logic         s_last = 1'b0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [111:0] m_data;
  logic         m_last;

  // Predictor copy of the registers and the path state.
  logic [15:0]       decel_r;
  logic [13:0]       delay_r;
  logic [19:0]       spacing_r;
  longint            anchor_x, anchor_y, anchor_z;
  longint unsigned   run_len, brake_len;
  logic              path_cut;

  point_t pending_points[$];
  emit_t  expected_points[$];
  point_t on_bus;
  int     phase = 0;
  int     tx_idle = 0, rx_idle = 0;
  int     mismatches = 0, points_sent = 0, points_seen = 0;
  int     hold_count = 0;
  bit     hold_done = 1'b0;

  braking_path_resample_and_truncate_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  always #5 clk_i = ~clk_i;

  // Exact floor square root of a sum of two or three 33-bit squares.
  function automatic longint unsigned floor_sqrt(logic [127:0] s);
    logic [127:0] r, t;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return r[63:0];
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic [127:0] square(longint v);
    return 128'(magnitude(v)) * 128'(magnitude(v));
  endfunction

  // Braking length in 1/1024 m from speed in 1/256 m/s.
  function automatic longint unsigned braking_len(logic [15:0] v);
    longint unsigned num, q;
    if (v < brt_pkg::SPD_MIN) return 0;
    if (decel_r == 0) return brt_pkg::LEN_MAX;
    num = 500 * longint'(v) * longint'(v) + longint'(delay_r) * longint'(v) * longint'(decel_r);
    q = num / (250 * longint'(decel_r));
    return (q > brt_pkg::LEN_MAX) ? brt_pkg::LEN_MAX : q;
  endfunction

  // Coordinate placed along the segment, truncated toward the anchor.
  function automatic logic [31:0] place_along(longint base, longint dc, longint unsigned remain,
                                              longint unsigned len3);
    logic [127:0] off;
    off = (128'(remain) * 128'(magnitude(dc))) / 128'(len3);
    return (dc < 0) ? 32'(base - longint'(off[63:0])) : 32'(base + longint'(off[63:0]));
  endfunction

  function automatic void push_point(logic [31:0] x, y, z, logic [15:0] hd, logic fin);
    emit_t e;
    e.x = x; e.y = y; e.z = z; e.hd = hd; e.fin = fin;
    expected_points = {expected_points, e};
  endfunction

  // Advance the path state by one accepted point and queue what it emits.
  function automatic void track_point(point_t p);
    longint          dx, dy, dz, px, py, pz;
    logic [127:0]    s2;
    longint unsigned remain, len3;
    px = longint'(signed'(p.x));
    py = longint'(signed'(p.y));
    pz = longint'(signed'(p.z));
    if (p.first) begin
      brake_len = braking_len(p.spd);
      run_len = 0;
      anchor_x = px; anchor_y = py; anchor_z = pz;
      path_cut = (brake_len == 0);
      push_point(p.x, p.y, p.z, p.hd, path_cut);
      if (!p.last) return;
    end
    if (path_cut) return;
    if (run_len >= brake_len) begin
      path_cut = 1'b1;
      return;
    end
    dx = px - anchor_x; dy = py - anchor_y; dz = pz - anchor_z;
    s2 = square(dx) + square(dy);
    if (!p.last && s2 <= 128'(spacing_r) * 128'(spacing_r)) return;
    remain = brake_len - run_len;
    if (128'(remain) * 128'(remain) <= s2) begin
      len3 = floor_sqrt(s2 + square(dz));
      push_point(place_along(anchor_x, dx, remain, len3), place_along(anchor_y, dy, remain, len3),
                 place_along(anchor_z, dz, remain, len3), p.hd, 1'b1);
      path_cut = 1'b1;
      return;
    end
    run_len += floor_sqrt(s2);
    if (run_len > brt_pkg::LEN_MAX) run_len = brt_pkg::LEN_MAX;
    anchor_x = px; anchor_y = py; anchor_z = pz;
    path_cut = p.last || run_len >= brake_len;
    push_point(p.x, p.y, p.z, p.hd, path_cut);
  endfunction

  // Sender: one transfer per point, with random gaps.
  always @(posedge clk_i) begin
    if (s_valid && s_ready) begin
      track_point(on_bus);
      points_sent++;
    end
    if (!s_valid || s_ready) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= tx_idle) begin
        on_bus = pending_points.pop_front();
        s_valid <= 1'b1;
        s_data <= {on_bus.spd, on_bus.hd, on_bus.z, on_bus.y, on_bus.x};
        s_user <= on_bus.first;
        s_last <= on_bus.last;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off in the third phase.
  always @(posedge clk_i) begin
    if (phase == 2 && !hold_done && rst_ni) begin
      m_ready <= 1'b0;
      hold_count++;
      if (hold_count == 3000) hold_done = 1'b1;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Monitor: compare each emitted point with the oldest expected one.
  always @(posedge clk_i) begin
    emit_t e;
    if (m_valid && m_ready) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h z=%h hd=%h end=%b", $time,
                 m_data[31:0], m_data[63:32], m_data[95:64], m_data[111:96], m_last);
        mismatches++;
      end else begin
        e = expected_points.pop_front();
        if (m_data[31:0] !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, m_data[31:0]);
          mismatches++;
        end
        if (m_data[63:32] !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, m_data[63:32]);
          mismatches++;
        end
        if (m_data[95:64] !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, m_data[95:64]);
          mismatches++;
        end
        if (m_data[111:96] !== e.hd) begin
          $display("%0t: out_heading expected %h actual %h", $time, e.hd, m_data[111:96]);
          mismatches++;
        end
        if (m_last !== e.fin) begin
          $display("%0t: path_end expected %b actual %b", $time, e.fin, m_last);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      brt_pkg::REG_MAX_DECEL:      decel_r = val[15:0];
      brt_pkg::REG_REACTION_DELAY: delay_r = val[13:0];
      brt_pkg::REG_MIN_SPACING:    spacing_r = val;
      default: ;
    endcase
  endtask

  task automatic add_point(logic [31:0] x, y, z, logic [15:0] hd, spd, logic first, last);
    point_t p;
    p.x = x; p.y = y; p.z = z; p.hd = hd; p.spd = spd; p.first = first; p.last = last;
    pending_points = {pending_points, p};
  endtask

  // A well-formed trajectory with random start, step size and speed.
  task automatic add_path();
    int          count, step;
    logic [31:0] x, y, z;
    logic [15:0] spd;
    count = $urandom_range(1, 10);
    case ($urandom_range(2))
      0:       step = 64;
      1:       step = 1500;
      default: step = 40000;
    endcase
    case ($urandom_range(3))
      0:       spd = 16'($urandom_range(0, 5));
      1:       spd = 16'($urandom);
      default: spd = 16'($urandom_range(128, 4096));
    endcase
    x = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 200000);
    y = $urandom;
    z = $urandom_range(0, 5000);
    for (int i = 0; i < count; i++) begin
      add_point(x, y, z, 16'($urandom), (i == 0) ? spd : 16'($urandom), i == 0, i == count - 1);
      x += $urandom_range(0, 2 * step) - step;
      y += $urandom_range(0, 2 * step) - step;
      z += $urandom_range(0, step / 4) - step / 8;
    end
  endtask

  // Let the block drain, including points that emit nothing.
  task automatic drain();
    while (pending_points.size() > 0 || s_valid || expected_points.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [19:0] decel_set[4]   = '{20'd256, 20'd1, 20'd65535, 20'd0};
    logic [19:0] delay_set[4]   = '{20'd0, 20'd10000, 20'd0, 20'd5000};
    logic [19:0] spacing_set[4] = '{20'd1024, 20'd0, 20'd1048575, 20'd512};
    decel_r = brt_pkg::DECEL_RST;
    delay_r = brt_pkg::DELAY_RST;
    spacing_r = brt_pkg::SPACE_RST;
    anchor_x = 0; anchor_y = 0; anchor_z = 0;
    run_len = 0; brake_len = 0; path_cut = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 5; ph++) begin
      phase = ph;
      tx_idle = (ph % 3 == 0) ? 9 : (ph % 3 == 1) ? 81 : 0;
      rx_idle = (ph % 3 == 0) ? 81 : (ph % 3 == 1) ? 9 : 0;
      if (ph < 4) begin
        write_reg(brt_pkg::REG_MAX_DECEL, decel_set[ph]);
        write_reg(brt_pkg::REG_REACTION_DELAY, delay_set[ph]);
        write_reg(brt_pkg::REG_MIN_SPACING, spacing_set[ph]);
      end else begin
        write_reg(brt_pkg::REG_MAX_DECEL, 20'($urandom_range(1, 65535)));
        write_reg(brt_pkg::REG_REACTION_DELAY, 20'($urandom_range(0, 10000)));
        write_reg(brt_pkg::REG_MIN_SPACING, 20'($urandom_range(0, 8192)));
      end
      if (ph == 0) begin
        // Stray point before any trajectory starts is ignored.
        add_point(32'd5, 32'd5, 32'd5, 16'h1234, 16'd500, 1'b0, 1'b0);
        // Single points: zero speed, speed under the floor, then a real speed.
        add_point(32'd100, 32'd200, 32'd300, 16'h0001, 16'd0, 1'b1, 1'b1);
        add_point(32'd100, 32'd200, 32'd300, 16'h0002, 16'd2, 1'b1, 1'b1);
        add_point(32'd100, 32'd200, 32'd300, 16'h0003, 16'd1000, 1'b1, 1'b1);
        // Opposite corners of the coordinate range at full speed.
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b1);
        // Length of 512 used up exactly on a last point.
        add_point(32'd0, 32'd0, 32'd0, 16'h0010, 16'd256, 1'b1, 1'b0);
        add_point(32'd512, 32'd0, 32'd0, 16'h0011, 16'd0, 1'b0, 1'b1);
        // A coincident point and a near one are both thinned and dropped.
        add_point(32'd0, 32'd0, 32'd0, 16'h0020, 16'd5000, 1'b1, 1'b0);
        add_point(32'd0, 32'd0, 32'd0, 16'h0021, 16'd0, 1'b0, 1'b0);
        add_point(32'd500, 32'd0, 32'd9, 16'h0022, 16'd0, 1'b0, 1'b0);
        add_point(32'd3000, -32'sd2000, 32'd40, 16'h0023, 16'd0, 1'b0, 1'b0);
        add_point(32'd90000, -32'sd90000, -32'sd800, 16'h0024, 16'd0, 1'b0, 1'b0);
        add_point(32'd95000, 32'd0, 32'd0, 16'h0025, 16'd0, 1'b0, 1'b1);
        // Points after the trajectory ended are ignored.
        add_point(32'd1, 32'd2, 32'd3, 16'h0030, 16'd100, 1'b0, 1'b0);
        add_point(32'd1, 32'd2, 32'd3, 16'h0031, 16'd100, 1'b0, 1'b1);
      end
      while (pending_points.size() < 270) begin
        if ($urandom_range(9) == 0)
          add_point($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          add_path();
      end
      drain();
    end

    $display("Sent %0d points over five register settings; checked %0d emitted points.",
             points_sent, points_seen);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #50ms;
    $display("Timeout with %0d points still expected.", expected_points.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/brt_pkg.sv
rtl/brt_iter.sv
rtl/brt_dpath.sv
rtl/brt_ctrl.sv
rtl/braking_path_resample_and_truncate_top.sv
tb/braking_path_resample_and_truncate_top_tb.sv
